### rtl/core/qmn_pkg.sv
// Shared types and fixed widths for the quaternion multiply and normalize unit.
package qmn_pkg;

   // Width of one component after block scaling, which keeps the largest in [2^30, 2^31).
   localparam int MAG_W = 31;
   // Width of the sum of squares and of the working words of the root.
   localparam int SUM_W = 64;
   // Width of the integer root, which is the divisor.
   localparam int ROOT_W = 32;
   // Number of root steps, one result bit each.
   localparam int ROOT_STEPS = 32;

   // One request: left and right quaternion, Q1.14 two's complement.
   typedef struct packed {
      logic signed [15:0] left_w;
      logic signed [15:0] left_x;
      logic signed [15:0] left_y;
      logic signed [15:0] left_z;
      logic signed [15:0] right_w;
      logic signed [15:0] right_x;
      logic signed [15:0] right_y;
      logic signed [15:0] right_z;
   } qmn_req_type;

   // One response: normalized product and the all-zero flag.
   typedef struct packed {
      logic signed [15:0] prod_w;
      logic signed [15:0] prod_x;
      logic signed [15:0] prod_y;
      logic signed [15:0] prod_z;
      logic               zero_norm;
   } qmn_rsp_type;

   // Scaled magnitudes and signs that ride along with the root and divide stages.
   typedef struct packed {
      logic [3:0][MAG_W-1:0] mag;
      logic [3:0]            neg;
      logic                  zero;
   } qmn_side_type;

   // Working words of the bitwise integer root.
   typedef struct packed {
      logic [SUM_W-1:0] rem;
      logic [SUM_W-1:0] root;
   } qmn_root_type;

endpackage

### rtl/core/qmn_sqrt_step.sv
// One registered step of the bitwise integer square root.
module qmn_sqrt_step #(
   parameter int STEP = 0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 enable,
   input  logic                 in_valid,
   input  qmn_pkg::qmn_side_type in_side,
   input  qmn_pkg::qmn_root_type in_state,
   output logic                 out_valid_ff,
   output qmn_pkg::qmn_side_type out_side_ff,
   output qmn_pkg::qmn_root_type out_state_ff
);

   localparam logic [qmn_pkg::SUM_W-1:0] BIT_VAL =
      {{(qmn_pkg::SUM_W-1){1'b0}}, 1'b1} << (62 - 2 * STEP);

   logic [qmn_pkg::SUM_W-1:0] trial;
   qmn_pkg::qmn_root_type     state_in;

   // Try the next result bit against the running remainder.
   always_comb begin
      trial = in_state.root + BIT_VAL;
      if (in_state.rem >= trial) begin
         state_in.rem  = in_state.rem - trial;
         state_in.root = (in_state.root >> 1) + BIT_VAL;
      end else begin
         state_in.rem  = in_state.rem;
         state_in.root = in_state.root >> 1;
      end
   end

   // Valid bit is reset; the payload only follows the pipeline enable.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (enable) begin
         out_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         out_side_ff  <= in_side;
         out_state_ff <= state_in;
      end
   end

endmodule

### rtl/core/qmn_div_step.sv
// One registered restoring-divide step for all four components at once.
module qmn_div_step #(
   parameter int FRAC_BITS = 14
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 enable,
   input  logic                                 in_valid,
   input  qmn_pkg::qmn_side_type                in_side,
   input  logic [qmn_pkg::ROOT_W-1:0]           in_divisor,
   input  logic [3:0][qmn_pkg::ROOT_W-1:0]      in_rem,
   input  logic [3:0][FRAC_BITS+1:0]            in_bits,
   output logic                                 out_valid_ff,
   output qmn_pkg::qmn_side_type                out_side_ff,
   output logic [qmn_pkg::ROOT_W-1:0]           out_divisor_ff,
   output logic [3:0][qmn_pkg::ROOT_W-1:0]      out_rem_ff,
   output logic [3:0][FRAC_BITS+1:0]            out_bits_ff
);

   localparam int QB = FRAC_BITS + 2;

   logic [3:0][qmn_pkg::ROOT_W:0]   shifted;
   logic [3:0]                      take;
   logic [3:0][qmn_pkg::ROOT_W-1:0] rem_in;
   logic [3:0][QB-1:0]              bits_in;

   // Bring down the next numerator bit and subtract the divisor where it fits.
   // The low word shifts the numerator bits out and the quotient bits in.
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         shifted[i] = {in_rem[i], in_bits[i][QB-1]};
         take[i]    = shifted[i] >= {1'b0, in_divisor};
         if (take[i]) begin
            rem_in[i] = qmn_pkg::ROOT_W'(shifted[i] - {1'b0, in_divisor});
         end else begin
            rem_in[i] = shifted[i][qmn_pkg::ROOT_W-1:0];
         end
         bits_in[i] = {in_bits[i][QB-2:0], take[i]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (enable) begin
         out_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         out_side_ff    <= in_side;
         out_divisor_ff <= in_divisor;
         out_rem_ff     <= rem_in;
         out_bits_ff    <= bits_in;
      end
   end

endmodule

### rtl/core/quaternion_multiply_normalize_unit.sv
// Top level: pipelined Hamilton product of two quaternions, renormalized to unit length.
//
//   channel   direction  ports                               carries
//   req       in         req_valid, req_stall, req_payload   left and right quaternion
//   rsp       out        rsp_valid, rsp_stall, rsp_payload   normalized product, zero flag
//
// A request enters every cycle while req_stall is low. The pipeline has registered stages for
// product, magnitude, block scaling and sum of squares, 32 stages of the bitwise root, a stage
// for the rounding add, FRAC_BITS + 2 divide stages and the output register.
// Reset clears only the valid bits of the stages. A stalled response holds the whole
// pipeline, so nothing is lost or repeated; req_stall is high exactly while that happens.
module quaternion_multiply_normalize_unit #(
   parameter int FRAC_BITS = 14
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  qmn_pkg::qmn_req_type req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output qmn_pkg::qmn_rsp_type rsp_payload
);

   localparam int QB    = FRAC_BITS + 2;
   localparam int NW    = FRAC_BITS + 32;
   localparam int LIM   = (FRAC_BITS > 14) ? 32767 : (1 << FRAC_BITS);
   localparam int MAG_W = qmn_pkg::MAG_W;
   localparam int RW    = qmn_pkg::ROOT_W;
   localparam int STEPS = qmn_pkg::ROOT_STEPS;

   logic pipe_advance;

   // The whole pipeline moves unless a finished response is held back.
   assign pipe_advance = !(rsp_valid && rsp_stall);
   assign req_stall    = !pipe_advance;

   // Stage 1: sixteen partial products.
   logic signed [15:0] lv [4];
   logic signed [15:0] rv [4];
   logic signed [31:0] prod_ff [4][4];
   logic               v1_ff;

   assign lv[0] = req_payload.left_w;
   assign lv[1] = req_payload.left_x;
   assign lv[2] = req_payload.left_y;
   assign lv[3] = req_payload.left_z;
   assign rv[0] = req_payload.right_w;
   assign rv[1] = req_payload.right_x;
   assign rv[2] = req_payload.right_y;
   assign rv[3] = req_payload.right_z;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (pipe_advance) begin
         v1_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_advance) begin
         for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++) begin
               prod_ff[i][j] <= lv[i] * rv[j];
            end
         end
      end
   end

   // Stage 2: Hamilton sums, then sign and magnitude of each component.
   logic signed [33:0] comp [4];
   logic [3:0][32:0]   a2_ff;
   logic [3:0]         neg2_ff;
   logic               v2_ff;

   assign comp[0] = 34'(prod_ff[0][0]) - 34'(prod_ff[1][1])
                  - 34'(prod_ff[2][2]) - 34'(prod_ff[3][3]);
   assign comp[1] = 34'(prod_ff[0][1]) + 34'(prod_ff[1][0])
                  + 34'(prod_ff[2][3]) - 34'(prod_ff[3][2]);
   assign comp[2] = 34'(prod_ff[0][2]) - 34'(prod_ff[1][3])
                  + 34'(prod_ff[2][0]) + 34'(prod_ff[3][1]);
   assign comp[3] = 34'(prod_ff[0][3]) + 34'(prod_ff[1][2])
                  - 34'(prod_ff[2][1]) + 34'(prod_ff[3][0]);

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (pipe_advance) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_advance) begin
         for (int i = 0; i < 4; i++) begin
            neg2_ff[i] <= comp[i][33];
            a2_ff[i]   <= comp[i][33] ? 33'(-comp[i]) : 33'(comp[i]);
         end
      end
   end

   // Stage 3: the leading one of the OR of all magnitudes is the leading one of the largest.
   logic [32:0]      or_all;
   logic [5:0]       lead_pos;
   logic [3:0][32:0] a3_ff;
   logic [3:0]       neg3_ff;
   logic             zero3_ff;
   logic             left3_ff;
   logic [4:0]       shl3_ff;
   logic [1:0]       shr3_ff;
   logic             v3_ff;

   always_comb begin
      or_all   = a2_ff[0] | a2_ff[1] | a2_ff[2] | a2_ff[3];
      lead_pos = 6'd0;
      for (int k = 0; k < 33; k++) begin
         if (or_all[k]) begin
            lead_pos = 6'(k);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (pipe_advance) begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_advance) begin
         a3_ff    <= a2_ff;
         neg3_ff  <= neg2_ff;
         zero3_ff <= (or_all == 33'd0);
         left3_ff <= (lead_pos < 6'd30);
         shl3_ff  <= 5'(6'd30 - lead_pos);
         shr3_ff  <= 2'(lead_pos - 6'd30);
      end
   end

   // Stage 4: block scaling, left shift or truncating right shift.
   logic [32:0]          wide [4];
   qmn_pkg::qmn_side_type side4_ff;
   logic                 v4_ff;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         wide[i] = left3_ff ? (a3_ff[i] << shl3_ff) : (a3_ff[i] >> shr3_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (pipe_advance) begin
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_advance) begin
         for (int i = 0; i < 4; i++) begin
            side4_ff.mag[i] <= wide[i][MAG_W-1:0];
         end
         side4_ff.neg  <= neg3_ff;
         side4_ff.zero <= zero3_ff;
      end
   end

   // Stage 5: squares of the scaled magnitudes.
   logic [2*MAG_W-1:0]   sq5_ff [4];
   qmn_pkg::qmn_side_type side5_ff;
   logic                 v5_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else if (pipe_advance) begin
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_advance) begin
         for (int i = 0; i < 4; i++) begin
            sq5_ff[i] <= side4_ff.mag[i] * side4_ff.mag[i];
         end
         side5_ff <= side4_ff;
      end
   end

   // Stage 6: sum of squares, which seeds the root.
   qmn_pkg::qmn_side_type root_side [STEPS+1];
   qmn_pkg::qmn_root_type root_state [STEPS+1];
   logic                  root_valid [STEPS+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         root_valid[0] <= 1'b0;
      end else if (pipe_advance) begin
         root_valid[0] <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_advance) begin
         root_side[0]       <= side5_ff;
         root_state[0].root <= '0;
         root_state[0].rem  <= qmn_pkg::SUM_W'(sq5_ff[0]) + qmn_pkg::SUM_W'(sq5_ff[1])
                             + qmn_pkg::SUM_W'(sq5_ff[2]) + qmn_pkg::SUM_W'(sq5_ff[3]);
      end
   end

   // Root stages: one result bit each.
   for (genvar g = 0; g < STEPS; g++) begin : g_root
      qmn_sqrt_step #(
         .STEP(g)
      ) u_step (
         .clock       (clock),
         .reset       (reset),
         .enable      (pipe_advance),
         .in_valid    (root_valid[g]),
         .in_side     (root_side[g]),
         .in_state    (root_state[g]),
         .out_valid_ff(root_valid[g+1]),
         .out_side_ff (root_side[g+1]),
         .out_state_ff(root_state[g+1])
      );
   end

   // Rounding add: numerator is magnitude times 2^FRAC_BITS plus half the root.
   logic [RW-1:0]         root_val;
   logic [NW-1:0]         numer [4];
   qmn_pkg::qmn_side_type div_side [QB+1];
   logic                  div_valid [QB+1];
   logic [RW-1:0]         div_divisor [QB+1];
   logic [3:0][RW-1:0]    div_rem [QB+1];
   logic [3:0][QB-1:0]    div_bits [QB+1];

   assign root_val = root_state[STEPS].root[RW-1:0];

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         numer[i] = (NW'(root_side[STEPS].mag[i]) << FRAC_BITS) + NW'(root_val >> 1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_valid[0] <= 1'b0;
      end else if (pipe_advance) begin
         div_valid[0] <= root_valid[STEPS];
      end
   end

   // The quotient fits in QB bits, so the upper numerator bits start out as the remainder.
   always_ff @(posedge clock) begin
      if (pipe_advance) begin
         div_side[0]    <= root_side[STEPS];
         div_divisor[0] <= root_val;
         for (int i = 0; i < 4; i++) begin
            div_rem[0][i]  <= RW'(numer[i][NW-1:QB]);
            div_bits[0][i] <= numer[i][QB-1:0];
         end
      end
   end

   // Divide stages: one quotient bit each for all four components.
   for (genvar d = 0; d < QB; d++) begin : g_div
      qmn_div_step #(
         .FRAC_BITS(FRAC_BITS)
      ) u_step (
         .clock         (clock),
         .reset         (reset),
         .enable        (pipe_advance),
         .in_valid      (div_valid[d]),
         .in_side       (div_side[d]),
         .in_divisor    (div_divisor[d]),
         .in_rem        (div_rem[d]),
         .in_bits       (div_bits[d]),
         .out_valid_ff  (div_valid[d+1]),
         .out_side_ff   (div_side[d+1]),
         .out_divisor_ff(div_divisor[d+1]),
         .out_rem_ff    (div_rem[d+1]),
         .out_bits_ff   (div_bits[d+1])
      );
   end

   // Output stage: saturate, apply sign, force zeros for an all-zero product.
   logic [QB-1:0]        q_clamp [4];
   logic [15:0]          q_mag [4];
   logic [15:0]          q_out [4];
   qmn_pkg::qmn_rsp_type rsp_in;
   qmn_pkg::qmn_rsp_type rsp_payload_ff;
   logic                 rsp_valid_ff;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         q_clamp[i] = (div_bits[QB][i] > QB'(LIM)) ? QB'(LIM) : div_bits[QB][i];
         q_mag[i]   = 16'(q_clamp[i]);
         if (div_side[QB].zero) begin
            q_out[i] = 16'd0;
         end else if (div_side[QB].neg[i]) begin
            q_out[i] = -q_mag[i];
         end else begin
            q_out[i] = q_mag[i];
         end
      end
      rsp_in.prod_w    = q_out[0];
      rsp_in.prod_x    = q_out[1];
      rsp_in.prod_y    = q_out[2];
      rsp_in.prod_z    = q_out[3];
      rsp_in.zero_norm = div_side[QB].zero;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (pipe_advance) begin
         rsp_valid_ff <= div_valid[QB];
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_advance) begin
         rsp_payload_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule
